// ===== rtl/core/qit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted item tokeniser package
// Shared widths, character constants, result kinds and the queue entry type.
// ----------------------------------------------------------------------------
package qit_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned KindW         = 3;
  localparam int unsigned ItemLenW      = 12;
  localparam int unsigned MaxCharsW     = 13;
  localparam int unsigned LengthBits    = 12;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [MaxCharsW-1:0] MaxCharsReset = 13'd128;

  localparam logic [CharW-1:0] CharEsc     = 8'h1B;
  localparam logic [CharW-1:0] CharNewline = 8'h0A;
  localparam logic [CharW-1:0] CharTab     = 8'h09;
  localparam logic [CharW-1:0] CharSpace   = 8'h20;
  localparam logic [CharW-1:0] CharStar    = 8'h2A;
  localparam logic [CharW-1:0] CharSemi    = 8'h3B;
  localparam logic [CharW-1:0] CharEquals  = 8'h3D;
  localparam logic [CharW-1:0] CharQuote   = 8'h22;
  localparam logic [CharW-1:0] CharLowerE  = 8'h65;
  localparam logic [CharW-1:0] CharUpperE  = 8'h45;
  localparam logic [CharW-1:0] CharLowerN  = 8'h6E;
  localparam logic [CharW-1:0] CharUpperN  = 8'h4E;

  typedef enum logic [KindW-1:0] {
    KindChar = 3'd0,
    KindUnquotedEnd = 3'd1,
    KindQuotedEnd = 3'd2,
    KindEquals = 3'd3,
    KindLineEnd = 3'd4,
    KindError = 3'd5
  } result_kind_e;

  // One queue entry: a first result, optionally followed by a line end.
  typedef struct packed {
    result_kind_e           kind;
    logic [CharW-1:0]       ch;
    logic [ItemLenW-1:0]    len;
    logic                   line_after;
  } entry_t;

endpackage

// ===== rtl/core/qit_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character input channel
// Valid/ready channel carrying one character or an end-of-input mark.
// ----------------------------------------------------------------------------
interface qit_in_if;
  logic                       valid;
  logic                       ready;
  logic [qit_pkg::CharW-1:0]  char_code;
  logic                       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

// ===== rtl/core/qit_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one tokeniser result per transfer.
// ----------------------------------------------------------------------------
interface qit_out_if;
  logic                         valid;
  logic                         ready;
  logic [qit_pkg::KindW-1:0]    result_kind;
  logic [qit_pkg::CharW-1:0]    char_value;
  logic [qit_pkg::ItemLenW-1:0] item_length;
  logic                         last_of_run;

  modport source (output valid, output result_kind, output char_value,
                  output item_length, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input char_value,
                input item_length, input last_of_run, output ready);
endinterface

// ===== rtl/core/qit_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokeniser front end
// Accepts characters, tracks the item phase and count, and queues results.
// ----------------------------------------------------------------------------
module qit_front #(
  parameter int unsigned LengthBits = qit_pkg::LengthBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qit_pkg::MaxCharsW-1:0]  cfg_wdata_i,
  qit_in_if.sink                         item_i,
  input  logic                           full_i,
  output logic                           push_o,
  output qit_pkg::entry_t                entry_o
);
  import qit_pkg::*;

  localparam int unsigned CmpW = (LengthBits + 1 > MaxCharsW) ? LengthBits + 1 : MaxCharsW;
  localparam logic [CmpW-1:0] LenMax = CmpW'((1 << LengthBits) - 1);

  typedef enum logic [2:0] {
    PhSkip = 3'd0,
    PhUnq  = 3'd1,
    PhQuo  = 3'd2,
    PhEsc  = 3'd3,
    PhDisc = 3'd4
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [LengthBits-1:0]   count_q, count_d;
  logic [MaxCharsW-1:0]    max_q;

  logic                    accept;
  logic                    push;
  logic [CharW-1:0]        c;
  logic                    nl, line_end, blank, is_eq, is_quote, is_star;
  logic [CharW-1:0]        mapped;
  logic [CmpW-1:0]         cnt_ext, n_ext, take_len;
  logic                    len_err;
  logic [ItemLenW-1:0]     cnt_len;
  entry_t                  take_entry;
  logic [LengthBits-1:0]   take_count;

  assign item_i.ready = !full_i;
  assign accept       = item_i.valid && item_i.ready;
  assign push_o       = accept && push;

  assign c        = item_i.char_code;
  assign nl       = item_i.end_of_input || (c == CharNewline);
  assign line_end = nl || (c == CharSemi);
  assign blank    = (c == CharSpace) || (c == CharTab);
  assign is_eq    = (c == CharEquals);
  assign is_quote = (c == CharQuote);
  assign is_star  = (c == CharStar);

  always_comb begin
    mapped = c;
    if (phase_q == PhEsc) begin
      if ((c == CharLowerE) || (c == CharUpperE)) begin
        mapped = CharEsc;
      end else if ((c == CharLowerN) || (c == CharUpperN)) begin
        mapped = CharNewline;
      end
    end
  end

  assign cnt_ext    = CmpW'(count_q);
  assign n_ext      = cnt_ext + CmpW'(1);
  assign cnt_len    = cnt_ext[ItemLenW-1:0];
  assign len_err    = (n_ext >= CmpW'(max_q)) || (n_ext > LenMax);
  assign take_len   = (n_ext > LenMax) ? LenMax : n_ext;
  assign take_count = len_err ? '0 : n_ext[LengthBits-1:0];

  always_comb begin
    take_entry.kind       = len_err ? KindError : KindChar;
    take_entry.ch         = len_err ? '0 : mapped;
    take_entry.len        = take_len[ItemLenW-1:0];
    take_entry.line_after = 1'b0;
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    push    = 1'b0;
    entry_o = '{kind: KindLineEnd, ch: '0, len: '0, line_after: 1'b0};
    case (phase_q)
      PhUnq: begin
        if (line_end || blank || is_eq) begin
          push               = 1'b1;
          entry_o.kind       = KindUnquotedEnd;
          entry_o.len        = cnt_len;
          entry_o.line_after = line_end;
          phase_d            = PhSkip;
          count_d            = '0;
        end else begin
          push    = 1'b1;
          entry_o = take_entry;
          phase_d = len_err ? PhDisc : PhUnq;
          count_d = take_count;
        end
      end
      PhQuo, PhEsc: begin
        if (nl) begin
          push               = 1'b1;
          entry_o.kind       = KindError;
          entry_o.len        = cnt_len;
          entry_o.line_after = 1'b1;
          phase_d            = PhSkip;
          count_d            = '0;
        end else if ((phase_q == PhQuo) && is_quote) begin
          push         = 1'b1;
          entry_o.kind = KindQuotedEnd;
          entry_o.len  = cnt_len;
          phase_d      = PhSkip;
          count_d      = '0;
        end else if ((phase_q == PhQuo) && is_star) begin
          phase_d = PhEsc;
        end else begin
          push    = 1'b1;
          entry_o = take_entry;
          phase_d = len_err ? PhDisc : PhQuo;
          count_d = take_count;
        end
      end
      PhDisc: begin
        if (line_end) begin
          push    = 1'b1;
          phase_d = PhSkip;
          count_d = '0;
        end
      end
      default: begin
        phase_d = PhSkip;
        count_d = '0;
        if (line_end) begin
          push = 1'b1;
        end else if (blank) begin
          push = 1'b0;
        end else if (is_quote) begin
          phase_d = PhQuo;
        end else if (is_eq) begin
          push         = 1'b1;
          entry_o.kind = KindEquals;
        end else begin
          push    = 1'b1;
          entry_o = take_entry;
          phase_d = len_err ? PhDisc : PhUnq;
          count_d = take_count;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      count_q <= '0;
      max_q   <= MaxCharsReset;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/core/qit_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokeniser result queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module qit_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qit_pkg::entry_t  wr_entry_i,
  input  logic             pop_i,
  output qit_pkg::entry_t  rd_entry_o,
  output logic             full_o,
  output logic             empty_o
);
  import qit_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  entry_t             store_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign rd_entry_o = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/qit_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokeniser back end
// Unpacks queue entries into single results held in an output register.
// ----------------------------------------------------------------------------
module qit_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qit_pkg::entry_t  entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  qit_out_if.source        result_o
);
  import qit_pkg::*;

  logic                  out_valid_q;
  logic                  pending_q;
  result_kind_e          kind_q;
  logic [CharW-1:0]      ch_q;
  logic [ItemLenW-1:0]   len_q;
  logic                  last_q;
  logic                  load;

  assign load  = !out_valid_q || result_o.ready;
  assign pop_o = load && !pending_q && !empty_i;

  assign result_o.valid       = out_valid_q;
  assign result_o.result_kind = kind_q;
  assign result_o.char_value  = ch_q;
  assign result_o.item_length = len_q;
  assign result_o.last_of_run = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pending_q   <= 1'b0;
    end else if (load) begin
      if (pending_q) begin
        out_valid_q <= 1'b1;
        pending_q   <= 1'b0;
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        pending_q   <= entry_i.line_after;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pending_q) begin
        kind_q <= KindLineEnd;
        ch_q   <= '0;
        len_q  <= '0;
        last_q <= 1'b1;
      end else if (!empty_i) begin
        kind_q <= entry_i.kind;
        ch_q   <= entry_i.ch;
        len_q  <= entry_i.len;
        last_q <= !entry_i.line_after;
      end
    end
  end

endmodule

// ===== rtl/core/quoted_item_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted item tokeniser
// Splits a character stream into plain, quoted and equals items, line ends and errors.
// ----------------------------------------------------------------------------
// One character is taken in every cycle while the four-entry result queue has
// room; a character is classified in the cycle of its transfer. Results leave
// through an output register at one per cycle while the receiver is ready, so a
// character that causes an item end followed by a line end yields two results,
// and the sustained rate is set by that register: one result transfer per cycle.
module quoted_item_tokenizer_unit #(
  parameter int unsigned LengthBits = qit_pkg::LengthBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qit_pkg::MaxCharsW-1:0]  cfg_wdata_i,
  qit_in_if.sink                         item_i,
  qit_out_if.source                      result_o
);
  import qit_pkg::*;

  entry_t  push_entry, pop_entry;
  logic    push, pop, full, empty;

  qit_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  qit_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_entry_i(push_entry),
    .pop_i     (pop),
    .rd_entry_o(pop_entry),
    .full_o    (full),
    .empty_o   (empty)
  );

  qit_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .result_o(result_o)
  );

endmodule
